// ===== rtl/sssm_pkg.sv =====
// Shared types, constants and arithmetic helpers of the selective SSM step unit.
`default_nettype none

package sssm_pkg;

	// input action codes
	localparam logic [2:0] ACT_LOAD_A    = 3'd0;
	localparam logic [2:0] ACT_LOAD_SKIP = 3'd1;
	localparam logic [2:0] ACT_LOAD_B    = 3'd2;
	localparam logic [2:0] ACT_LOAD_C    = 3'd3;
	localparam logic [2:0] ACT_PROCESS   = 3'd4;
	localparam logic [2:0] ACT_CLEAR     = 3'd5;

	typedef enum logic [2:0] {
		OP_LOAD_A,
		OP_LOAD_SKIP,
		OP_LOAD_B,
		OP_LOAD_C,
		OP_PROC,
		OP_CLEAR
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [3:0]         channel;
		logic [3:0]         state_index;
		logic signed [31:0] value;
		logic [30:0]        step_size;
	} queue_entry_t;

	typedef struct packed {
		logic               sat;
		logic signed [31:0] val;
	} clip_t;

	typedef enum logic [4:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_SKIP_MUL,
		BK_SKIP_ACC,
		BK_RD,
		BK_MUL_Z,
		BK_EXP_CHK,
		BK_MUL_L,
		BK_FRAC,
		BK_MUL_I,
		BK_EXP_SH,
		BK_GAIN,
		BK_DIV,
		BK_MUL_B,
		BK_BB,
		BK_MUL_H,
		BK_MUL_X,
		BK_HNEW,
		BK_MUL_C,
		BK_ACC,
		BK_OUT
	} back_state_t;

	localparam int QUEUE_DEPTH = 2;

	localparam logic signed [31:0] Q_ONE   = 32'sd65536;
	localparam logic signed [31:0] LOG2E_Q = 32'sd94548;
	localparam logic signed [31:0] E_MAX   = 32'sh7FFFFFFF;
	localparam logic signed [47:0] EXP_HI  = 48'sd720896;
	localparam logic signed [47:0] EXP_LO  = -48'sd786432;
	localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
	localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

	// gain divider: 47-bit dividend magnitude, 32-bit divisor magnitude
	localparam int DIVD_W    = 47;
	localparam int DIVS_W    = 32;
	localparam int DIV_STEPS = DIVD_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// Q16.16 product back to Q16.16, round half up (floor shift)
	function automatic logic signed [47:0] round_q(input logic signed [63:0] v);
		logic signed [63:0] t;
		t = v + 64'sd32768;
		return t[63:16];
	endfunction

	function automatic clip_t clip32(input logic signed [63:0] v);
		clip_t r;
		if (v > S32_MAX) begin
			r.sat = 1'b1;
			r.val = E_MAX;
		end else if (v < S32_MIN) begin
			r.sat = 1'b1;
			r.val = 32'sh80000000;
		end else begin
			r.sat = 1'b0;
			r.val = v[31:0];
		end
		return r;
	endfunction

	// 2^(i/16) in Q16.16
	function automatic logic [17:0] pow2_frac(input logic [4:0] i);
		logic [17:0] r;
		unique case (i)
			5'd0:    r = 18'd65536;
			5'd1:    r = 18'd68438;
			5'd2:    r = 18'd71468;
			5'd3:    r = 18'd74632;
			5'd4:    r = 18'd77936;
			5'd5:    r = 18'd81386;
			5'd6:    r = 18'd84990;
			5'd7:    r = 18'd88752;
			5'd8:    r = 18'd92682;
			5'd9:    r = 18'd96785;
			5'd10:   r = 18'd101070;
			5'd11:   r = 18'd105545;
			5'd12:   r = 18'd110218;
			5'd13:   r = 18'd115098;
			5'd14:   r = 18'd120194;
			5'd15:   r = 18'd125515;
			5'd16:   r = 18'd131072;
			default: r = 18'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/sssm_queue.sv =====
// Short in-order queue of classified words between front and back.
`default_nettype none

module sssm_queue import sssm_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire queue_entry_t push_entry,
	output logic              full,
	input  wire logic         pop,
	output queue_entry_t      head,
	output logic              empty
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	queue_entry_t entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = entry_q[rd_q];

	// depth is a power of two, pointers wrap naturally
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_q] <= push_entry;
	end

endmodule

`default_nettype wire

// ===== rtl/sssm_front.sv =====
// Input side: takes words, drops the ignored ones, classifies the rest.
`default_nettype none

module sssm_front import sssm_pkg::*; #(
	parameter int CHANNELS   = 16,
	parameter int STATE_SIZE = 16
) (
	input  wire logic               item_valid,
	output logic                    item_stall,
	input  wire logic [2:0]         action,
	input  wire logic [3:0]         channel,
	input  wire logic [3:0]         state_index,
	input  wire logic signed [31:0] value,
	input  wire logic [30:0]        step_size,
	input  wire logic               q_full,
	input  wire logic               clearing,
	output logic                    push,
	output queue_entry_t            push_entry
);

	logic ch_ok, st_ok, keep;
	op_t  op;

	assign ch_ok = int'(channel) < CHANNELS;
	assign st_ok = int'(state_index) < STATE_SIZE;

	always_comb begin
		op   = OP_PROC;
		keep = 1'b0;
		unique case (action)
			ACT_LOAD_A: begin
				op   = OP_LOAD_A;
				keep = ch_ok && st_ok;
			end
			ACT_LOAD_SKIP: begin
				op   = OP_LOAD_SKIP;
				keep = ch_ok;
			end
			ACT_LOAD_B: begin
				op   = OP_LOAD_B;
				keep = st_ok;
			end
			ACT_LOAD_C: begin
				op   = OP_LOAD_C;
				keep = st_ok;
			end
			ACT_PROCESS: begin
				op   = OP_PROC;
				keep = ch_ok;
			end
			ACT_CLEAR: begin
				op   = OP_CLEAR;
				keep = 1'b1;
			end
			default: begin
				op   = OP_PROC;
				keep = 1'b0;
			end
		endcase
	end

	assign item_stall = q_full || clearing;
	assign push       = item_valid && !item_stall && keep;

	assign push_entry.op          = op;
	assign push_entry.channel     = channel;
	assign push_entry.state_index = state_index;
	assign push_entry.value       = value;
	assign push_entry.step_size   = step_size;

endmodule

`default_nettype wire

// ===== rtl/sssm_div.sv =====
// Restoring divider on magnitudes, one quotient bit per cycle.
`default_nettype none

module sssm_div import sssm_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [DIVD_W-1:0] dividend,
	input  wire logic [DIVS_W-1:0] divisor,
	output logic                   done,
	output logic [DIVD_W-1:0]      quotient
);

	logic                 busy_q, done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIVS_W-1:0]    rem_q, div_q;
	logic [DIVD_W-1:0]    quo_q;
	logic [DIVS_W:0]      rem_sh;
	logic [DIVS_W+1:0]    trial;
	logic                 ge;

	assign rem_sh = {rem_q, quo_q[DIVD_W-1]};
	assign trial  = {1'b0, rem_sh} - {2'b00, div_q};
	assign ge     = !trial[DIVS_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? trial[DIVS_W-1:0] : rem_sh[DIVS_W-1:0];
			quo_q <= {quo_q[DIVD_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// ===== rtl/sssm_back.sv =====
// Execution side: tables, hidden state, sequencer over states, output register.
`default_nettype none

module sssm_back import sssm_pkg::*; #(
	parameter int CHANNELS   = 16,
	parameter int STATE_SIZE = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire queue_entry_t  q_head,
	input  wire logic          q_empty,
	output logic               q_pop,
	output logic               clearing,
	output logic               result_valid,
	input  wire logic          result_stall,
	output logic [3:0]         out_channel,
	output logic signed [31:0] y_value,
	output logic               saturated
);

	localparam int DEPTH  = CHANNELS * STATE_SIZE;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int ST_W   = (STATE_SIZE > 1) ? $clog2(STATE_SIZE) : 1;

	logic signed [31:0] decay_mem [DEPTH];
	logic signed [31:0] hid_mem   [DEPTH];
	logic signed [31:0] skip_mem  [CHANNELS];
	logic signed [31:0] b_mem     [STATE_SIZE];
	logic signed [31:0] c_mem     [STATE_SIZE];

	back_state_t state_q, state_d;

	logic [ST_W-1:0]   n_q;
	logic [ADDR_W-1:0] clr_q;
	logic              result_valid_q;

	logic [3:0]         ch_q;
	logic signed [31:0] x_q;
	logic [30:0]        delta_q;
	logic signed [31:0] skip_rd, a_rd, b_rd, c_rd, h_rd;
	logic signed [63:0] prod_q, acc_q;
	logic signed [20:0] z_q;
	logic signed [5:0]  k_q;
	logic [17:0]        lo_q;
	logic [12:0]        diff_q;
	logic [11:0]        part_q;
	logic signed [31:0] e_q, gain_q, bb_q, h_q;
	logic signed [47:0] t1_q;
	logic               flag_q;
	logic [3:0]         out_ch_q;
	logic signed [31:0] y_q;
	logic               sat_q;

	logic              wr_a, wr_skip, wr_b, wr_c, rd_skip, rd_st, hid_we, div_start, out_load;
	logic [ADDR_W-1:0] hid_waddr;
	logic signed [31:0] hid_wdata, mul_a, mul_b;

	logic [ADDR_W-1:0] head_addr, at_addr;
	logic [CH_W-1:0]   head_ch;
	logic [ST_W-1:0]   head_st;
	logic              out_free, n_last, clr_last, head_proc;

	assign head_addr = ADDR_W'(int'(q_head.channel) * STATE_SIZE + int'(q_head.state_index));
	assign at_addr   = ADDR_W'(int'(ch_q) * STATE_SIZE + int'(n_q));
	assign head_ch   = CH_W'(q_head.channel);
	assign head_st   = ST_W'(q_head.state_index);
	assign out_free  = !result_valid_q || !result_stall;
	assign n_last    = (n_q == ST_W'(STATE_SIZE - 1));
	assign clr_last  = (clr_q == ADDR_W'(DEPTH - 1));
	assign head_proc = !q_empty && (q_head.op == OP_PROC);

	// shared arithmetic
	logic signed [47:0] rnd_w;
	logic               z_hi, z_lo;
	logic [17:0]        lo_w, hi_w, interp_w;
	logic [32:0]        shl_w;
	logic               shl_sat;
	logic [5:0]         sh_n;
	logic [18:0]        rnd_add, shr_w;
	logic signed [31:0] e_up, e_dn;
	logic signed [32:0] ediff;
	logic [32:0]        ediff_mag;
	logic [DIVD_W-1:0]  num_mag, quo;
	logic [DIVS_W-1:0]  den_mag;
	logic               q_neg, div_done;
	logic signed [63:0] quo_s;
	clip_t              div_c, bb_c, h_c, y_c;

	assign rnd_w = round_q(prod_q);
	assign z_hi  = rnd_w > EXP_HI;
	assign z_lo  = rnd_w < EXP_LO;

	assign lo_w = pow2_frac({1'b0, rnd_w[15:12]});
	assign hi_w = pow2_frac(5'({1'b0, rnd_w[15:12]}) + 5'd1);

	// interpolate, then scale by 2^k with rounding on the way down
	assign interp_w = lo_q + 18'((prod_q[24:0] + 25'd2048) >> 12);
	assign shl_w    = 33'(interp_w) << k_q[3:0];
	assign shl_sat  = shl_w[32] | shl_w[31];
	assign e_up     = shl_sat ? E_MAX : $signed(shl_w[31:0]);
	assign sh_n     = 6'(-k_q);
	assign rnd_add  = 19'(1) << (sh_n[4:0] - 5'd1);
	assign shr_w    = (19'(interp_w) + rnd_add) >> sh_n[4:0];
	assign e_dn     = $signed(32'(shr_w));

	// gain = ((e - 1) << 16) / A, signs handled outside the divider
	assign ediff     = 33'(e_q) - 33'(Q_ONE);
	assign ediff_mag = ediff[32] ? 33'(-ediff) : 33'(ediff);
	assign num_mag   = {ediff_mag[30:0], 16'b0};
	assign den_mag   = a_rd[31] ? 32'(-a_rd) : 32'(a_rd);
	assign q_neg     = ediff[32] ^ a_rd[31];
	assign quo_s     = q_neg ? -$signed(64'(quo)) : $signed(64'(quo));

	assign div_c = clip32(quo_s);
	assign bb_c  = clip32(64'(rnd_w));
	assign h_c   = clip32(64'(t1_q) + 64'(rnd_w));
	assign y_c   = clip32(acc_q);

	sssm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (num_mag),
		.divisor  (den_mag),
		.done     (div_done),
		.quotient (quo)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_CLEAR:    if (clr_last) state_d = BK_IDLE;
			BK_IDLE: begin
				if (!q_empty) begin
					if (q_head.op == OP_PROC) state_d = BK_SKIP_MUL;
					else if (q_head.op == OP_CLEAR) state_d = BK_CLEAR;
				end
			end
			BK_SKIP_MUL: state_d = BK_SKIP_ACC;
			BK_SKIP_ACC: state_d = BK_RD;
			BK_RD:       state_d = BK_MUL_Z;
			BK_MUL_Z:    state_d = BK_EXP_CHK;
			BK_EXP_CHK:  state_d = (z_hi || z_lo) ? BK_GAIN : BK_MUL_L;
			BK_MUL_L:    state_d = BK_FRAC;
			BK_FRAC:     state_d = BK_MUL_I;
			BK_MUL_I:    state_d = BK_EXP_SH;
			BK_EXP_SH:   state_d = BK_GAIN;
			BK_GAIN:     state_d = (a_rd == '0) ? BK_MUL_B : BK_DIV;
			BK_DIV:      if (div_done) state_d = BK_MUL_B;
			BK_MUL_B:    state_d = BK_BB;
			BK_BB:       state_d = BK_MUL_H;
			BK_MUL_H:    state_d = BK_MUL_X;
			BK_MUL_X:    state_d = BK_HNEW;
			BK_HNEW:     state_d = BK_MUL_C;
			BK_MUL_C:    state_d = BK_ACC;
			BK_ACC:      state_d = n_last ? BK_OUT : BK_RD;
			BK_OUT:      if (out_free) state_d = BK_IDLE;
			default:     state_d = BK_IDLE;
		endcase
	end

	// decoded controls and multiplier operands
	always_comb begin
		q_pop     = 1'b0;
		wr_a      = 1'b0;
		wr_skip   = 1'b0;
		wr_b      = 1'b0;
		wr_c      = 1'b0;
		rd_skip   = 1'b0;
		rd_st     = 1'b0;
		hid_we    = 1'b0;
		hid_waddr = at_addr;
		hid_wdata = h_c.val;
		div_start = 1'b0;
		out_load  = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		unique case (state_q)
			BK_CLEAR: begin
				hid_we    = 1'b1;
				hid_waddr = clr_q;
				hid_wdata = '0;
			end
			BK_IDLE: begin
				q_pop   = !q_empty;
				wr_a    = !q_empty && (q_head.op == OP_LOAD_A);
				wr_skip = !q_empty && (q_head.op == OP_LOAD_SKIP);
				wr_b    = !q_empty && (q_head.op == OP_LOAD_B);
				wr_c    = !q_empty && (q_head.op == OP_LOAD_C);
				rd_skip = head_proc;
			end
			BK_SKIP_MUL: begin
				mul_a = skip_rd;
				mul_b = x_q;
			end
			BK_RD:       rd_st = 1'b1;
			BK_MUL_Z: begin
				mul_a = $signed({1'b0, delta_q});
				mul_b = a_rd;
			end
			BK_MUL_L: begin
				mul_a = 32'(z_q);
				mul_b = LOG2E_Q;
			end
			BK_MUL_I: begin
				mul_a = $signed({19'b0, diff_q});
				mul_b = $signed({20'b0, part_q});
			end
			BK_GAIN:     div_start = (a_rd != '0);
			BK_MUL_B: begin
				mul_a = gain_q;
				mul_b = b_rd;
			end
			BK_MUL_H: begin
				mul_a = e_q;
				mul_b = h_rd;
			end
			BK_MUL_X: begin
				mul_a = bb_q;
				mul_b = x_q;
			end
			BK_HNEW:     hid_we = 1'b1;
			BK_MUL_C: begin
				mul_a = c_rd;
				mul_b = h_q;
			end
			BK_OUT:      out_load = out_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= BK_CLEAR;
			n_q            <= '0;
			clr_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_CLEAR) clr_q <= clr_last ? '0 : clr_q + 1'b1;
			if (state_q == BK_IDLE && head_proc) n_q <= '0;
			else if (state_q == BK_ACC && !n_last) n_q <= n_q + 1'b1;
			if (out_load) result_valid_q <= 1'b1;
			else if (!result_stall) result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a) * 64'(mul_b);
		unique case (state_q)
			BK_IDLE: begin
				if (head_proc) begin
					ch_q    <= q_head.channel;
					x_q     <= q_head.value;
					delta_q <= q_head.step_size;
					flag_q  <= 1'b0;
				end
			end
			BK_SKIP_ACC: acc_q <= 64'(rnd_w);
			BK_EXP_CHK: begin
				if (z_hi) begin
					e_q    <= E_MAX;
					flag_q <= 1'b1;
				end else if (z_lo) begin
					e_q <= '0;
				end else begin
					z_q <= 21'(rnd_w);
				end
			end
			BK_FRAC: begin
				k_q    <= rnd_w[21:16];
				lo_q   <= lo_w;
				diff_q <= 13'(hi_w - lo_w);
				part_q <= rnd_w[11:0];
			end
			BK_EXP_SH: begin
				e_q <= k_q[5] ? e_dn : e_up;
				if (!k_q[5] && shl_sat) flag_q <= 1'b1;
			end
			BK_GAIN:     if (a_rd == '0) gain_q <= $signed({1'b0, delta_q});
			BK_DIV: begin
				if (div_done) begin
					gain_q <= div_c.val;
					if (div_c.sat) flag_q <= 1'b1;
				end
			end
			BK_BB: begin
				bb_q <= bb_c.val;
				if (bb_c.sat) flag_q <= 1'b1;
			end
			BK_MUL_X:    t1_q <= rnd_w;
			BK_HNEW: begin
				h_q <= h_c.val;
				if (h_c.sat) flag_q <= 1'b1;
			end
			BK_ACC:      acc_q <= acc_q + 64'(rnd_w);
			BK_OUT: begin
				if (out_free) begin
					out_ch_q <= ch_q;
					y_q      <= y_c.val;
					sat_q    <= flag_q | y_c.sat;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_a) decay_mem[head_addr] <= q_head.value;
		if (rd_st) a_rd <= decay_mem[at_addr];
	end

	always_ff @(posedge clk) begin
		if (wr_skip) skip_mem[head_ch] <= q_head.value;
		if (rd_skip) skip_rd <= skip_mem[head_ch];
	end

	always_ff @(posedge clk) begin
		if (wr_b) b_mem[head_st] <= q_head.value;
		if (rd_st) b_rd <= b_mem[n_q];
	end

	always_ff @(posedge clk) begin
		if (wr_c) c_mem[head_st] <= q_head.value;
		if (rd_st) c_rd <= c_mem[n_q];
	end

	always_ff @(posedge clk) begin
		if (hid_we) hid_mem[hid_waddr] <= hid_wdata;
		if (rd_st) h_rd <= hid_mem[at_addr];
	end

	assign clearing     = (state_q == BK_CLEAR);
	assign result_valid = result_valid_q;
	assign out_channel  = out_ch_q;
	assign y_value      = y_q;
	assign saturated    = sat_q;

endmodule

`default_nettype wire

// ===== rtl/selective_ssm_recurrent_step_unit.sv =====
// Top level of the selective state-space recurrent step unit.
//
// Input channel (item_valid / item_stall): one word per item. Actions load the
// decay table A, the skip gains, the token vectors B and C, start a process
// step, or clear the hidden state. Ignored words (unused actions, channel or
// state out of range) are accepted and dropped without a result.
// Output channel (result_valid / result_stall): one word per process item with
// the channel, the saturated Q16.16 y and the clip flag. The output register
// holds while stalled; the back end waits in its final step until it drains.
// A front end classifies words into a two-entry queue, so loads and further
// items are taken while the back end computes.
// Sequencing: a load or clear is taken from the queue in the idle state. A
// process item runs, per state, 15 sequencer steps around one shared 32x32
// multiplier plus the bit-serial gain divider, which dominates; states whose
// A is zero or whose exponent falls outside the table window skip the
// divider or the exp steps.
// Reset and clear: after reset, and for every clear item, the back end sweeps
// the hidden memory, one entry a cycle. No item is accepted while the sweep
// runs. Table memories come up undefined.
`default_nettype none

module selective_ssm_recurrent_step_unit import sssm_pkg::*; #(
	parameter int CHANNELS   = 16,
	parameter int STATE_SIZE = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_stall,
	input  wire logic [2:0]         action,
	input  wire logic [3:0]         channel,
	input  wire logic [3:0]         state_index,
	input  wire logic signed [31:0] value,
	input  wire logic [30:0]        step_size,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output logic [3:0]              out_channel,
	output logic signed [31:0]      y_value,
	output logic                    saturated
);

	logic         q_push, q_full, q_pop, q_empty, clearing;
	queue_entry_t push_entry, q_head;

	// front end: accept and classify
	sssm_front #(
		.CHANNELS   (CHANNELS),
		.STATE_SIZE (STATE_SIZE)
	) u_front (
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.action      (action),
		.channel     (channel),
		.state_index (state_index),
		.value       (value),
		.step_size   (step_size),
		.q_full      (q_full),
		.clearing    (clearing),
		.push        (q_push),
		.push_entry  (push_entry)
	);

	// decoupling queue
	sssm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head       (q_head),
		.empty      (q_empty)
	);

	// back end: tables, hidden state, sequencer and output register
	sssm_back #(
		.CHANNELS   (CHANNELS),
		.STATE_SIZE (STATE_SIZE)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_head       (q_head),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.clearing     (clearing),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.out_channel  (out_channel),
		.y_value      (y_value),
		.saturated    (saturated)
	);

	// no write into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full))
		else $error("queue push while full");

	// no pop from an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_pop && q_empty))
		else $error("queue pop while empty");

	// nothing enters the queue during a hidden-state sweep
	a_sweep_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !q_push)
		else $error("word queued during clear sweep");

	// results only name channels that exist
	a_out_channel: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (int'(out_channel) < CHANNELS))
		else $error("result for a channel out of range");

endmodule

`default_nettype wire

// ===== test/selective_ssm_recurrent_step_unit_tb.sv =====
// Self-checking testbench for the selective SSM recurrent step unit.
`default_nettype none

module selective_ssm_recurrent_step_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sssm_pkg::*;

	localparam int CH_N = 16;
	localparam int ST_N = 16;
	// action codes the block drops without a result
	localparam logic [2:0] ACT_SPARE_6 = 3'd6;
	localparam logic [2:0] ACT_SPARE_7 = 3'd7;
	localparam longint ONE = 65536;

	typedef struct {
		logic [2:0]         action;
		logic [3:0]         channel;
		logic [3:0]         state_index;
		logic signed [31:0] value;
		logic [30:0]        step_size;
	} word_t;

	typedef struct {
		logic [3:0]         ch;
		logic signed [31:0] y;
		logic               sat;
	} y_word_t;

	// Tracks the tables and hidden state, predicts y for every process word
	// and compares against what comes out of the result channel.
	class ssm_scoreboard;
		int      decay_a [CH_N*ST_N];
		int      skip_g  [CH_N];
		int      b_vec   [ST_N];
		int      c_vec   [ST_N];
		int      h_state [CH_N*ST_N];
		y_word_t y_pending[$];
		int      fails;

		function new();
			foreach (h_state[i]) h_state[i] = 0;
			fails = 0;
		endfunction

		// Q16.16 product back to Q16.16, half up with floor
		static function longint rnd(longint v);
			return (v + 32768) >>> 16;
		endfunction

		static function longint sat32(longint v, inout bit flag);
			if (v > 64'sd2147483647) begin
				flag = 1;
				return 64'sd2147483647;
			end
			if (v < -64'sd2147483648) begin
				flag = 1;
				return -64'sd2147483648;
			end
			return v;
		endfunction

		static function longint frac_pow2(int i);
			longint tbl[17] = '{65536, 68438, 71468, 74632, 77936, 81386, 84990,
				88752, 92682, 96785, 101070, 105545, 110218, 115098, 120194,
				125515, 131072};
			return tbl[i];
		endfunction

		// exp(z) via 2^(z*log2e), table plus linear interpolation
		static function longint q_exp(longint z, inout bit flag);
			longint y, k, f, lo, hi, m;
			int idx, s;
			if (z > 11 * ONE) begin
				flag = 1;
				return 64'sd2147483647;
			end
			if (z < -12 * ONE) return 0;
			y = rnd(z * 94548);
			k = y >>> 16;
			f = y - k * ONE;
			idx = int'(f >> 12) & 15;
			lo = frac_pow2(idx);
			hi = frac_pow2(idx + 1);
			m = lo + (((hi - lo) * (f & 'hFFF) + 2048) >>> 12);
			if (k >= 0) return sat32(m << k, flag);
			s = int'(-k);
			return (m + (64'sd1 << (s - 1))) >>> s;
		endfunction

		function void note_word(word_t w);
			longint x, dt, acc, a, e, gain, bb, h;
			bit flag;
			int at;
			y_word_t r;
			x = longint'(w.value);
			dt = longint'({33'd0, w.step_size});
			flag = 0;
			case (w.action)
				ACT_LOAD_A:    decay_a[w.channel*ST_N + w.state_index] = w.value;
				ACT_LOAD_SKIP: skip_g[w.channel] = w.value;
				ACT_LOAD_B:    b_vec[w.state_index] = w.value;
				ACT_LOAD_C:    c_vec[w.state_index] = w.value;
				ACT_CLEAR:     foreach (h_state[i]) h_state[i] = 0;
				ACT_PROCESS: begin
					acc = rnd(longint'(skip_g[w.channel]) * x);
					for (int n = 0; n < ST_N; n++) begin
						at = w.channel*ST_N + n;
						a = decay_a[at];
						e = q_exp(rnd(dt * a), flag);
						if (a == 0) gain = dt;
						else gain = sat32(((e - ONE) * ONE) / a, flag);
						bb = sat32(rnd(gain * longint'(b_vec[n])), flag);
						h = rnd(e * longint'(h_state[at])) + rnd(bb * x);
						h = sat32(h, flag);
						h_state[at] = int'(h);
						acc += rnd(longint'(c_vec[n]) * h);
					end
					acc = sat32(acc, flag);
					r.ch = w.channel;
					r.y = acc[31:0];
					r.sat = flag;
					y_pending.push_back(r);
				end
				default: ;
			endcase
		endfunction

		function void check_y(logic [3:0] ch, logic signed [31:0] y, logic sat);
			y_word_t e;
			if (y_pending.size() == 0) begin
				$error("result word with nothing pending: out_channel %0d", ch);
				fails++;
				return;
			end
			e = y_pending.pop_front();
			if (ch !== e.ch) begin
				$error("out_channel expected %0d actual %0d", e.ch, ch);
				fails++;
			end
			if (y !== e.y) begin
				$error("y_value expected %0d actual %0d", e.y, y);
				fails++;
			end
			if (sat !== e.sat) begin
				$error("saturated expected %0b actual %0b", e.sat, sat);
				fails++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	logic [2:0] action = '0;
	logic [3:0] channel = '0;
	logic [3:0] state_index = '0;
	logic signed [31:0] value = '0;
	logic [30:0] step_size = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [3:0] out_channel;
	logic signed [31:0] y_value;
	logic saturated;

	ssm_scoreboard sb = new();
	word_t stim_q[$];      // words waiting to be offered
	word_t cur_word;       // word currently on the input ports
	int src_idle_pct = 0;  // sender idle odds per cycle
	int rcv_stall_pct = 0; // receiver stall odds per cycle

	selective_ssm_recurrent_step_unit #(.CHANNELS(CH_N), .STATE_SIZE(ST_N)) u_dut (
		.clk, .arst_n, .item_valid, .item_stall, .action, .channel, .state_index,
		.value, .step_size, .result_valid, .result_stall, .out_channel, .y_value,
		.saturated
	);

	always #4 clk = ~clk;

	// input side: note accepted word, hold while stalled, else maybe offer next
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall) sb.note_word(cur_word);
			if (!(item_valid && item_stall)) begin
				if (stim_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					cur_word = stim_q.pop_front();
					action <= cur_word.action;
					channel <= cur_word.channel;
					state_index <= cur_word.state_index;
					value <= cur_word.value;
					step_size <= cur_word.step_size;
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// result side: check accepted words, stall at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall)
				sb.check_y(out_channel, y_value, saturated);
			result_stall <= ($urandom_range(99) < rcv_stall_pct);
		end
	end

	function automatic word_t mk(logic [2:0] act, int ch, int sn, logic [31:0] v,
			logic [30:0] dt);
		word_t w;
		w.action = act;
		w.channel = 4'(ch);
		w.state_index = 4'(sn);
		w.value = v;
		w.step_size = dt;
		return w;
	endfunction

	// table word: mostly modest values, now and then any 32-bit pattern
	function automatic logic [31:0] gain_word();
		if ($urandom_range(9) < 8) return 32'(int'($urandom_range(4*ONE)) - 2*ONE);
		return $urandom;
	endfunction

	// decay entry: mostly negative (stable), some zero, positive and wild
	function automatic logic [31:0] decay_word();
		int pick;
		pick = $urandom_range(99);
		if (pick < 60) return 32'(-int'($urandom_range(8*ONE)));
		if (pick < 70) return 32'd0;
		if (pick < 80) return 32'($urandom_range(4*ONE));
		return $urandom;
	endfunction

	function automatic word_t rand_word();
		int pick;
		logic [30:0] dt;
		logic [31:0] x;
		pick = $urandom_range(99);
		dt = ($urandom_range(9) < 8) ? 31'($urandom_range(2*ONE)) : 31'($urandom);
		x = ($urandom_range(9) < 8) ? 32'(int'($urandom_range(8*ONE)) - 4*ONE)
			: $urandom;
		if (pick < 45) return mk(ACT_PROCESS, $urandom_range(15), $urandom_range(15), x, dt);
		if (pick < 65) return mk(ACT_LOAD_A, $urandom_range(15), $urandom_range(15),
			decay_word(), 31'($urandom));
		if (pick < 75) return mk(ACT_LOAD_SKIP, $urandom_range(15), $urandom_range(15),
			gain_word(), 31'($urandom));
		if (pick < 85) return mk(ACT_LOAD_B, $urandom_range(15), $urandom_range(15),
			gain_word(), 31'($urandom));
		if (pick < 95) return mk(ACT_LOAD_C, $urandom_range(15), $urandom_range(15),
			gain_word(), 31'($urandom));
		if (pick < 98) return mk(ACT_CLEAR, $urandom_range(15), $urandom_range(15),
			$urandom, 31'($urandom));
		return mk(pick[0] ? ACT_SPARE_6 : ACT_SPARE_7, $urandom_range(15),
			$urandom_range(15), $urandom, 31'($urandom));
	endfunction

	task automatic drain_stim();
		while (stim_q.size() != 0 || item_valid) @(posedge clk);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// fill every table entry before any process word can read it:
		// channel 0 all-zero decay, channel 1 strongly positive, channel 2
		// strongly negative, rest random
		for (int c = 0; c < CH_N; c++)
			for (int n = 0; n < ST_N; n++)
				stim_q.push_back(mk(ACT_LOAD_A, c, n,
					(c == 0) ? 32'd0 : (c == 1) ? 32'(5*ONE) :
					(c == 2) ? 32'(-10*ONE) : decay_word(), 31'd0));
		for (int i = 0; i < CH_N; i++) begin
			stim_q.push_back(mk(ACT_LOAD_SKIP, i, 0, gain_word(), 31'd0));
			stim_q.push_back(mk(ACT_LOAD_B, 0, i, gain_word(), 31'd0));
			stim_q.push_back(mk(ACT_LOAD_C, 0, i, gain_word(), 31'd0));
		end

		// directed corners
		stim_q.push_back(mk(ACT_PROCESS, 0, 0, 32'h7FFFFFFF, 31'h7FFFFFFF)); // zero A, max delta
		stim_q.push_back(mk(ACT_PROCESS, 1, 0, 32'(ONE), 31'(3*ONE)));     // exponent too large
		stim_q.push_back(mk(ACT_PROCESS, 2, 0, 32'(ONE), 31'(2*ONE)));     // exponent too small
		stim_q.push_back(mk(ACT_PROCESS, 3, 15, 32'h80000000, 31'd0));     // min x, zero delta
		stim_q.push_back(mk(ACT_LOAD_SKIP, 4, 0, 32'h80000000, 31'd0));
		stim_q.push_back(mk(ACT_PROCESS, 4, 0, 32'h80000000, 31'(ONE)));   // skip*x overflow
		stim_q.push_back(mk(ACT_LOAD_SKIP, 5, 0, 32'h7FFFFFFF, 31'd0));
		stim_q.push_back(mk(ACT_PROCESS, 5, 0, 32'h7FFFFFFF, 31'h7FFFFFFF));
		stim_q.push_back(mk(ACT_PROCESS, 15, 0, 32'd0, 31'd1));
		stim_q.push_back(mk(ACT_SPARE_6, 15, 15, 32'hFFFFFFFF, 31'h7FFFFFFF));
		stim_q.push_back(mk(ACT_SPARE_7, 0, 0, 32'd0, 31'd0));
		stim_q.push_back(mk(ACT_CLEAR, 0, 0, 32'd0, 31'd0));
		stim_q.push_back(mk(ACT_PROCESS, 0, 0, 32'(ONE), 31'(ONE)));       // right after clear
		stim_q.push_back(mk(ACT_PROCESS, 5, 0, 32'h7FFFFFFF, 31'h7FFFFFFF));
		drain_stim();

		// random phases: no idling, sender idle, receiver stalling, both
		for (int ph = 0; ph < 4; ph++) begin
			src_idle_pct = (ph == 1) ? 58 : (ph == 3) ? 38 : 0;
			rcv_stall_pct = (ph == 2) ? 58 : (ph == 3) ? 38 : 0;
			repeat (183) stim_q.push_back(rand_word());
			drain_stim();
		end

		while (sb.y_pending.size() != 0) @(posedge clk);
		repeat (1200) @(posedge clk);
		if (sb.fails == 0)
			$display("selective_ssm_recurrent_step_unit verification clean");
		else
			$display("selective_ssm_recurrent_step_unit verification failed");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("selective_ssm_recurrent_step_unit verification failed");
		$finish;
	end

endmodule

`default_nettype wire

// ===== selective_ssm_recurrent_step_unit.f =====
rtl/sssm_pkg.sv
rtl/sssm_queue.sv
rtl/sssm_front.sv
rtl/sssm_div.sv
rtl/sssm_back.sv
rtl/selective_ssm_recurrent_step_unit.sv
test/selective_ssm_recurrent_step_unit_tb.sv
